@@ hdl/pidpc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidpc_pkg
// Shared types and constants of the positional PID controller.
// ----------------------------------------------------------------------------
package pidpc_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int INTEGRAL_WIDTH_DEF = 48;

    // Fixed field widths
    localparam int GAIN_W     = 32;   // Q16.16 gains
    localparam int PERIOD_W   = 16;   // Q0.16 sample period
    localparam int DRIVE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fraction bits of the P/D sum and of the final accumulator
    localparam int PD_FRAC  = 16;
    localparam int OUT_FRAC = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_COEFF = 3'd4;

    // Request to the serial multiplier
    typedef struct packed {
        logic start;
        logic long_run;   // multiplier word is the full integral width
    } t_mul_ctl;

endpackage

@@ hdl/pidpc_mul.sv @@
// ----------------------------------------------------------------------------
// pidpc_mul
// Bit-serial signed shift-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pidpc_mul #(
    parameter int INTEGRAL_WIDTH = pidpc_pkg::INTEGRAL_WIDTH_DEF,
    parameter int SHORT_W        = pidpc_pkg::SAMPLE_WIDTH_DEF + 2
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  pidpc_pkg::t_mul_ctl                         i_ctl,
    input  logic [pidpc_pkg::GAIN_W-1:0]                i_mcand,
    input  logic [INTEGRAL_WIDTH-1:0]                   i_mplr,
    output logic                                        o_done,
    output logic [pidpc_pkg::GAIN_W+SHORT_W:0]          o_prod_short,
    output logic [pidpc_pkg::GAIN_W+INTEGRAL_WIDTH:0]   o_prod_long
);
    import pidpc_pkg::*;

    localparam int IW = INTEGRAL_WIDTH;
    localparam int HW = GAIN_W + 1;
    localparam int CW = $clog2(IW);
    localparam logic [CW-1:0] LAST_LONG  = CW'(IW - 1);
    localparam logic [CW-1:0] LAST_SHORT = CW'(SHORT_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_long;
    logic [CW-1:0]        r_cnt;
    logic [GAIN_W-1:0]    r_mcand;
    logic [HW-1:0]        r_hi;
    logic [IW-1:0]        r_lo;   // multiplier bits out at the bottom, product bits in at the top

    logic                 last_step;
    logic [HW-1:0]        mc_ext;
    logic [HW-1:0]        addend;
    logic [HW-1:0]        n_hi_sum;

    always_comb begin
        last_step = (r_cnt == (r_long ? LAST_LONG : LAST_SHORT));
        mc_ext    = {r_mcand[GAIN_W-1], r_mcand};
        // sign bit of the multiplier has negative weight
        if (r_lo[0]) begin
            addend = last_step ? (~mc_ext + HW'(1)) : mc_ext;
        end else begin
            addend = '0;
        end
        n_hi_sum = r_hi + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_long <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_long  <= i_ctl.long_run;
                r_cnt   <= '0;
                r_mcand <= i_mcand;
                r_hi    <= '0;
                r_lo    <= i_mplr;
            end else if (r_busy) begin
                r_hi  <= {n_hi_sum[HW-1], n_hi_sum[HW-1:1]};
                r_lo  <= {n_hi_sum[0], r_lo[IW-1:1]};
                r_cnt <= r_cnt + CW'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done       = r_done;
    assign o_prod_short = {r_hi, r_lo[IW-1 -: SHORT_W]};
    assign o_prod_long  = {r_hi, r_lo};

endmodule

@@ hdl/pid_position_controller.sv @@
// ----------------------------------------------------------------------------
// pid_position_controller
// Positional PID regulator with saturating integral and clipped drive output.
// ----------------------------------------------------------------------------
// One measurement is taken per transfer and one drive value is returned.
// error = measurement - setpoint; the integral gains error * sample_period
// and saturates to INTEGRAL_WIDTH bits; drive = P + I + D rounded down to an
// integer and saturated to 32 bits; tuser flags a clipped integral or drive.
// All four products run on one bit-serial multiplier, one multiplier bit per
// cycle: three products of SAMPLE_WIDTH+2 bits and one of INTEGRAL_WIDTH
// bits. The next measurement is taken only once the result of the last one
// sits in the output register, and then also while the result waits there.
// Write the configuration only while no sample is in flight.
// ----------------------------------------------------------------------------
module pid_position_controller #(
    parameter int SAMPLE_WIDTH   = pidpc_pkg::SAMPLE_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = pidpc_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_cfg_wen,
    input  logic [pidpc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pidpc_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,

    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,   // measurement

    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [pidpc_pkg::DRIVE_W-1:0]          m_axis_tdata,   // drive
    output logic [0:0]                             m_axis_tuser    // clipped
);
    import pidpc_pkg::*;

    localparam int SW      = SAMPLE_WIDTH;
    localparam int IW      = INTEGRAL_WIDTH;
    localparam int EW      = SW + 1;
    localparam int SHORT_W = SW + 2;
    localparam int PSW     = GAIN_W + 1 + SHORT_W;
    localparam int PLW     = GAIN_W + 1 + IW;
    localparam int AW      = ((IW > PSW) ? IW : PSW) + 1;
    localparam int FW      = ((PLW > PSW + PD_FRAC) ? PLW : PSW + PD_FRAC) + 1;
    localparam int DTOP    = OUT_FRAC + DRIVE_W - 1;

    typedef enum logic [1:0] {S_IDLE, S_START, S_RUN, S_OUT} t_state;
    typedef enum logic [1:0] {OP_INC, OP_P, OP_D, OP_I} t_op;

    // configuration
    logic [SW-1:0]       r_setpoint;
    logic [PERIOD_W-1:0] r_period;
    logic [GAIN_W-1:0]   r_kp;
    logic [GAIN_W-1:0]   r_ki;
    logic [GAIN_W-1:0]   r_kd;

    t_state              r_state;
    t_op                 r_op;
    logic [EW-1:0]       r_err;
    logic [EW-1:0]       r_prev;
    logic [IW-1:0]       r_integral;
    logic [PSW-1:0]      r_pd;
    logic                r_clip;
    logic [DRIVE_W-1:0]  r_drive;
    logic                r_out_valid;
    logic [DRIVE_W-1:0]  r_out_drive;
    logic                r_out_clip;

    t_mul_ctl            mul_ctl;
    logic [GAIN_W-1:0]   mul_mcand;
    logic [IW-1:0]       mul_mplr;
    logic                mul_done;
    logic [PSW-1:0]      prod_short;
    logic [PLW-1:0]      prod_long;

    logic [SW-1:0]       meas;
    logic [EW-1:0]       n_err;
    logic [SHORT_W-1:0]  err_delta;
    logic [AW-1:0]       int_sum;
    logic                int_ovf;
    logic [IW-1:0]       int_sat;
    logic [FW-1:0]       acc;
    logic                drive_ovf;
    logic [DRIVE_W-1:0]  drive_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_period   <= '0;
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                REG_SETPOINT:    r_setpoint <= i_cfg_wdata[SW-1:0];
                REG_PERIOD:      r_period   <= i_cfg_wdata[PERIOD_W-1:0];
                REG_PROP_GAIN:   r_kp       <= i_cfg_wdata[GAIN_W-1:0];
                REG_INT_GAIN:    r_ki       <= i_cfg_wdata[GAIN_W-1:0];
                REG_DERIV_COEFF: r_kd       <= i_cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        meas      = s_axis_tdata[SW-1:0];
        n_err     = {meas[SW-1], meas} - {r_setpoint[SW-1], r_setpoint};
        err_delta = {r_prev[EW-1], r_prev} - {r_err[EW-1], r_err};

        mul_ctl.start    = (r_state == S_START);
        mul_ctl.long_run = 1'b0;
        unique case (r_op)
            OP_INC: begin
                mul_mcand = {{(GAIN_W-PERIOD_W){1'b0}}, r_period};
                mul_mplr  = {{(IW-EW){r_err[EW-1]}}, r_err};
            end
            OP_P: begin
                mul_mcand = r_kp;
                mul_mplr  = {{(IW-EW){r_err[EW-1]}}, r_err};
            end
            OP_D: begin
                mul_mcand = r_kd;
                mul_mplr  = {{(IW-SHORT_W){err_delta[SHORT_W-1]}}, err_delta};
            end
            OP_I: begin
                mul_mcand        = r_ki;
                mul_mplr         = r_integral;
                mul_ctl.long_run = 1'b1;
            end
            default: begin
                mul_mcand = '0;
                mul_mplr  = '0;
            end
        endcase
    end

    pidpc_mul #(
        .INTEGRAL_WIDTH (IW),
        .SHORT_W        (SHORT_W)
    ) u_mul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mul_ctl),
        .i_mcand      (mul_mcand),
        .i_mplr       (mul_mplr),
        .o_done       (mul_done),
        .o_prod_short (prod_short),
        .o_prod_long  (prod_long)
    );

    // integral update with saturation
    always_comb begin
        int_sum = {{(AW-IW){r_integral[IW-1]}}, r_integral}
                + {{(AW-PSW){prod_short[PSW-1]}}, prod_short};
        int_ovf = !((&int_sum[AW-1:IW-1]) || !(|int_sum[AW-1:IW-1]));
        if (int_ovf) begin
            int_sat = int_sum[AW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            int_sat = int_sum[IW-1:0];
        end
    end

    // final sum in Q.32, floor to integer, saturate
    always_comb begin
        acc = {{(FW-PLW){prod_long[PLW-1]}}, prod_long}
            + {{(FW-PSW-PD_FRAC){r_pd[PSW-1]}}, r_pd, {PD_FRAC{1'b0}}};
        drive_ovf = !((&acc[FW-1:DTOP]) || !(|acc[FW-1:DTOP]));
        if (drive_ovf) begin
            drive_sat = acc[FW-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                  : {1'b0, {(DRIVE_W-1){1'b1}}};
        end else begin
            drive_sat = acc[DTOP:OUT_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_INC;
            r_err       <= '0;
            r_prev      <= '0;
            r_integral  <= '0;
            r_pd        <= '0;
            r_clip      <= 1'b0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
            r_out_drive <= '0;
            r_out_clip  <= 1'b0;
        end else begin
            // in S_OUT the output slot is handled by the state itself
            if (r_out_valid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_err   <= n_err;
                        r_op    <= OP_INC;
                        r_clip  <= 1'b0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (mul_done) begin
                        unique case (r_op)
                            OP_INC: begin
                                r_integral <= int_sat;
                                r_clip     <= int_ovf;
                                r_op       <= OP_P;
                                r_state    <= S_START;
                            end
                            OP_P: begin
                                r_pd    <= prod_short;
                                r_op    <= OP_D;
                                r_state <= S_START;
                            end
                            OP_D: begin
                                r_pd    <= r_pd + prod_short;
                                r_op    <= OP_I;
                                r_state <= S_START;
                            end
                            OP_I: begin
                                r_drive <= drive_sat;
                                r_clip  <= r_clip | drive_ovf;
                                r_prev  <= r_err;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_OUT: begin
                    // hand over once the output slot is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_drive <= r_drive;
                        r_out_clip  <= r_clip;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_drive;
    assign m_axis_tuser[0] = r_out_clip;

endmodule
